// ----- rtl/core/ntp_pkg.sv -----
package ntp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ID_BITS      = 8;
    localparam int STEP_BITS    = $clog2(CORDIC_STEPS + 1);

    localparam logic [1:0] OP_POSE = 2'd0;
    localparam logic [1:0] OP_CAND = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_LIN     = 2'd1;
    localparam logic [1:0] REG_ANG     = 2'd2;
    localparam logic [1:0] REG_NEAREST = 2'd3;

    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [27:0] HALF_PI_Q16 = 28'sd102944;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic signed [15:0] heading;
        logic [7:0]  target_id;
        logic        last_in_list;
    } in_item_t;

    typedef struct packed {
        logic [20:0] linear_speed;
        logic signed [19:0] angular_speed;
        logic        catch_request;
        logic [7:0]  catch_id;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // latch the accepted item
        logic do_pose;
        logic do_diff;     // form dx, dy from candidate or goal
        logic do_square;   // dx*dx, dy*dy
        logic do_sum;      // dist_sq, compare
        logic do_cand;     // update best / goal
        logic start_iter;  // set up root and cordic
        logic do_iter;     // one root step and one cordic step
        logic do_err;      // heading error and wrap
        logic do_mult;     // gain products into output
        logic do_catch;    // catch output, drop goal
    } ntp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       tick_ok;
        logic       beyond;
        logic       iter_done;
    } ntp_sts_t;

    function automatic logic signed [27:0] atan_q16(input logic [4:0] i);
        logic signed [27:0] v;
        begin
            case (i)
                5'd0:  v = 28'sd51472;
                5'd1:  v = 28'sd30386;
                5'd2:  v = 28'sd16055;
                5'd3:  v = 28'sd8150;
                5'd4:  v = 28'sd4091;
                5'd5:  v = 28'sd2047;
                5'd6:  v = 28'sd1024;
                5'd7:  v = 28'sd512;
                5'd8:  v = 28'sd256;
                5'd9:  v = 28'sd128;
                5'd10: v = 28'sd64;
                5'd11: v = 28'sd32;
                5'd12: v = 28'sd16;
                5'd13: v = 28'sd8;
                5'd14: v = 28'sd4;
                5'd15: v = 28'sd2;
                5'd16: v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/nearest_target_pursuit.sv -----
// channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_item  (opcode, pos_x, pos_y, heading, target_id, last)
// out      | out_valid | out_stall | out_item (linear_speed, angular_speed, catch, catch_id)
// config   | cfg_wr    | -         | cfg_idx, cfg_data
// a pose item ends in S_DISPATCH, a candidate in S_DECIDE, an idle tick in S_DISPATCH
// a pursuing tick runs the shared root/cordic loop: 17 root steps
// (cordic needs 16 of them), and then S_ITER sees the loop done
// a catch tick goes from S_DECIDE straight to S_HOLD
// one item at a time; the output register lets the next item in while a result waits
// a stalled output holds the finishing tick in its last state until the register frees
// rst_n clears config to defaults and all pose, goal and list state
module nearest_target_pursuit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ntp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output ntp_pkg::out_item_t out_item,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_idx,
    input  logic [15:0]        cfg_data
);

    ntp_pkg::ntp_cmd_t cmd;
    ntp_pkg::ntp_sts_t sts;

    // sequencer
    ntp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // state, squares, root and cordic loop, gains
    ntp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_item)
    );

endmodule

// ----- rtl/core/ntp_ctrl.sv -----
module ntp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ntp_pkg::ntp_sts_t sts,
    output ntp_pkg::ntp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DIFF, S_SQUARE, S_SUM, S_DECIDE,
        S_START, S_ITER, S_ERR, S_MULT, S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.opcode == ntp_pkg::OP_POSE)
                begin
                    cmd.do_pose = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sts.opcode == ntp_pkg::OP_CAND)
                begin
                    state_next = S_DIFF;
                end
                else if (sts.opcode == ntp_pkg::OP_TICK && sts.tick_ok)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIFF:
            begin
                cmd.do_diff = 1'b1;
                state_next  = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.do_square = 1'b1;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                cmd.do_sum = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.opcode == ntp_pkg::OP_CAND)
                begin
                    cmd.do_cand = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sts.beyond)
                begin
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_START:
            begin
                cmd.start_iter = 1'b1;
                state_next     = S_ITER;
            end
            S_ITER:
            begin
                cmd.do_iter = 1'b1;
                if (sts.iter_done)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.do_err = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                // wait for the output register to be free
                if (!out_valid_next)
                begin
                    cmd.do_mult    = sts.beyond;
                    cmd.do_catch   = !sts.beyond;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("result dropped under stall");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_mult || cmd.do_catch) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten");

endmodule

// ----- rtl/core/ntp_dp.sv -----
module ntp_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ntp_pkg::in_item_t  in_item,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_idx,
    input  logic [15:0]        cfg_data,
    input  ntp_pkg::ntp_cmd_t  cmd,
    output ntp_pkg::ntp_sts_t  sts,
    output ntp_pkg::out_item_t out_item
);

    localparam int SB = ntp_pkg::STEP_BITS;

    logic [15:0] radius_reg;
    logic [7:0]  lin_gain_reg, ang_gain_reg;
    logic        nearest_reg;

    ntp_pkg::in_item_t item_reg;
    logic [15:0] robot_x_reg, robot_y_reg;
    logic signed [15:0] heading_reg;
    logic        pose_seen_reg;
    logic [15:0] goal_x_reg, goal_y_reg;
    logic [ntp_pkg::ID_BITS-1:0] goal_id_reg, best_id_reg;
    logic        goal_valid_reg, list_open_reg;
    logic [15:0] best_x_reg, best_y_reg;
    logic [32:0] best_d2_reg;

    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0] sqx_reg, sqy_reg;
    logic [31:0] r2_reg;
    logic [32:0] d2_reg;
    logic        beyond_reg;

    // root and cordic
    logic [33:0] rem_reg, root_reg, bit_reg;
    logic signed [27:0] cx_reg, cy_reg, cz_reg;
    logic [SB-1:0] step_reg;
    logic [16:0] dist_reg;
    logic signed [17:0] err_reg;
    ntp_pkg::out_item_t out_reg;

    logic [15:0] px, py;
    logic [32:0] d2_sum;
    logic signed [27:0] xs, ys, ax, ay;
    logic signed [17:0] ang, err0;
    logic [33:0] trial;
    logic [4:0]  step5;
    logic signed [27:0] z_round;
    logic [24:0] lin_prod;
    logic signed [26:0] ang_prod;

    assign px = (item_reg.opcode == ntp_pkg::OP_CAND) ? item_reg.pos_x : goal_x_reg;
    assign py = (item_reg.opcode == ntp_pkg::OP_CAND) ? item_reg.pos_y : goal_y_reg;
    assign d2_sum = sqx_reg[32:0] + sqy_reg[32:0];
    assign xs = cx_reg >>> step_reg;
    assign ys = cy_reg >>> step_reg;
    assign trial = root_reg + bit_reg;
    assign step5 = 5'(step_reg);
    assign z_round = (cz_reg + 28'sd4) >>> 3;
    assign ang = z_round[17:0];
    assign err0 = ang - 18'(heading_reg);
    assign ax = 28'(dx_reg) <<< 8;
    assign ay = 28'(dy_reg) <<< 8;
    assign lin_prod = lin_gain_reg * dist_reg;
    assign ang_prod = $signed({1'b0, ang_gain_reg}) * err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= 16'd2048;
            lin_gain_reg   <= 8'd32;
            ang_gain_reg   <= 8'd96;
            nearest_reg    <= 1'b1;
            robot_x_reg    <= '0;
            robot_y_reg    <= '0;
            heading_reg    <= '0;
            pose_seen_reg  <= 1'b0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            goal_id_reg    <= '0;
            goal_valid_reg <= 1'b0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_id_reg    <= '0;
            best_d2_reg    <= '0;
            list_open_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    ntp_pkg::REG_RADIUS:  radius_reg   <= cfg_data;
                    ntp_pkg::REG_LIN:     lin_gain_reg <= cfg_data[7:0];
                    ntp_pkg::REG_ANG:     ang_gain_reg <= cfg_data[7:0];
                    ntp_pkg::REG_NEAREST: nearest_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.do_pose)
            begin
                robot_x_reg   <= item_reg.pos_x;
                robot_y_reg   <= item_reg.pos_y;
                heading_reg   <= item_reg.heading;
                pose_seen_reg <= 1'b1;
            end
            if (cmd.do_cand)
            begin
                if (!list_open_reg || (nearest_reg && d2_reg < best_d2_reg))
                begin
                    best_x_reg  <= item_reg.pos_x;
                    best_y_reg  <= item_reg.pos_y;
                    best_id_reg <= item_reg.target_id[ntp_pkg::ID_BITS-1:0];
                    best_d2_reg <= d2_reg;
                end
                if (item_reg.last_in_list)
                begin
                    goal_valid_reg <= 1'b1;
                    list_open_reg  <= 1'b0;
                    if (!list_open_reg || (nearest_reg && d2_reg < best_d2_reg))
                    begin
                        goal_x_reg  <= item_reg.pos_x;
                        goal_y_reg  <= item_reg.pos_y;
                        goal_id_reg <= item_reg.target_id[ntp_pkg::ID_BITS-1:0];
                    end
                    else
                    begin
                        goal_x_reg  <= best_x_reg;
                        goal_y_reg  <= best_y_reg;
                        goal_id_reg <= best_id_reg;
                    end
                end
                else
                begin
                    list_open_reg <= 1'b1;
                end
            end
            if (cmd.do_catch)
            begin
                goal_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.do_diff)
        begin
            dx_reg <= $signed({1'b0, px}) - $signed({1'b0, robot_x_reg});
            dy_reg <= $signed({1'b0, py}) - $signed({1'b0, robot_y_reg});
        end
        if (cmd.do_square)
        begin
            sqx_reg <= 34'(dx_reg * dx_reg);
            sqy_reg <= 34'(dy_reg * dy_reg);
            r2_reg  <= radius_reg * radius_reg;
        end
        if (cmd.do_sum)
        begin
            d2_reg     <= d2_sum;
            beyond_reg <= d2_sum > {1'b0, r2_reg};
        end
        if (cmd.start_iter)
        begin
            rem_reg  <= {1'b0, d2_reg};
            root_reg <= '0;
            bit_reg  <= 34'h1 << 32;
            step_reg <= '0;
            if (dx_reg < 0)
            begin
                if (dy_reg >= 0)
                begin
                    cx_reg <= ay;
                    cy_reg <= -ax;
                    cz_reg <= ntp_pkg::HALF_PI_Q16;
                end
                else
                begin
                    cx_reg <= -ay;
                    cy_reg <= ax;
                    cz_reg <= -ntp_pkg::HALF_PI_Q16;
                end
            end
            else
            begin
                cx_reg <= ax;
                cy_reg <= ay;
                cz_reg <= '0;
            end
        end
        if (cmd.do_iter)
        begin
            if (bit_reg != 0)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            if (step_reg < SB'(ntp_pkg::CORDIC_STEPS))
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + ntp_pkg::atan_q16(step5);
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - ntp_pkg::atan_q16(step5);
                end
                step_reg <= step_reg + 1'b1;
            end
        end
        if (cmd.do_err)
        begin
            dist_reg <= root_reg[16:0];
            if (err0 > ntp_pkg::PI_Q13)
            begin
                err_reg <= err0 - ntp_pkg::TWO_PI_Q13;
            end
            else if (err0 < -ntp_pkg::PI_Q13)
            begin
                err_reg <= err0 + ntp_pkg::TWO_PI_Q13;
            end
            else
            begin
                err_reg <= err0;
            end
        end
        if (cmd.do_mult)
        begin
            out_reg.linear_speed  <= lin_prod[24:4];
            out_reg.angular_speed <= 20'(ang_prod >>> 4);
            out_reg.catch_request <= 1'b0;
            out_reg.catch_id      <= '0;
        end
        if (cmd.do_catch)
        begin
            out_reg.linear_speed  <= '0;
            out_reg.angular_speed <= '0;
            out_reg.catch_request <= 1'b1;
            out_reg.catch_id      <= 8'(goal_id_reg);
        end
    end

    assign sts.opcode    = item_reg.opcode;
    assign sts.tick_ok   = pose_seen_reg && goal_valid_reg;
    assign sts.beyond    = beyond_reg;
    assign sts.iter_done = (bit_reg == 0) && (step_reg >= SB'(ntp_pkg::CORDIC_STEPS));
    assign out_item      = out_reg;

    a_catch_goal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_catch |=> !goal_valid_reg)
        else $error("goal kept after catch");
    a_list_close: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_cand && item_reg.last_in_list |=> goal_valid_reg && !list_open_reg)
        else $error("list not closed");
    a_pose_seen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pose |=> pose_seen_reg)
        else $error("pose flag not set");

endmodule

// ----- bench/ntp_checker.sv -----
// watches both channels, models the pursuit controller, compares results
module ntp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ntp_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ntp_pkg::out_item_t out_item,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_idx,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 n_pursuit,
    output int                 n_catch
);

    // model configuration and state
    logic [15:0] m_radius;
    logic [7:0]  m_lin, m_ang;
    logic        m_nearest;
    logic [15:0] rob_x, rob_y, rob_head;
    logic        pose_ok;
    logic [15:0] goal_x, goal_y;
    logic [7:0]  goal_tag;
    logic        goal_ok;
    logic [15:0] best_x, best_y;
    logic [7:0]  best_tag;
    logic [32:0] best_d2;
    logic        list_open;

    ntp_pkg::out_item_t cmd_q[$];

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'd1 << 34;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in q3.13
    function automatic longint bearing(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = ntp_pkg::HALF_PI_Q16;
            end
            else
            begin
                x = -y; y = t; z = -ntp_pkg::HALF_PI_Q16;
            end
        end
        for (int i = 0; i < ntp_pkg::CORDIC_STEPS; i++)
        begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += longint'(ntp_pkg::atan_q16(i[4:0]));
            end
            else
            begin
                x -= ys; y += xs; z -= longint'(ntp_pkg::atan_q16(i[4:0]));
            end
        end
        return fshift(z + 4, 3);
    endfunction

    function automatic longint range_sq(logic [15:0] px, logic [15:0] py);
        longint dx, dy;
        dx = longint'(px) - longint'(rob_x);
        dy = longint'(py) - longint'(rob_y);
        return dx * dx + dy * dy;
    endfunction

    task automatic steer(input ntp_pkg::in_item_t it);
        longint d2, dx, dy, err, hd;
        ntp_pkg::out_item_t r;
        case (it.opcode)
            ntp_pkg::OP_POSE:
            begin
                rob_x = it.pos_x; rob_y = it.pos_y; rob_head = it.heading;
                pose_ok = 1'b1;
            end
            ntp_pkg::OP_CAND:
            begin
                d2 = range_sq(it.pos_x, it.pos_y);
                if (!list_open || (m_nearest && d2 < longint'(best_d2)))
                begin
                    best_x = it.pos_x; best_y = it.pos_y;
                    best_tag = it.target_id; best_d2 = d2[32:0];
                end
                if (it.last_in_list)
                begin
                    goal_x = best_x; goal_y = best_y; goal_tag = best_tag;
                    goal_ok = 1'b1; list_open = 1'b0;
                end
                else
                    list_open = 1'b1;
            end
            ntp_pkg::OP_TICK:
            begin
                if (pose_ok && goal_ok)
                begin
                    d2 = range_sq(goal_x, goal_y);
                    if (d2 > longint'(m_radius) * longint'(m_radius))
                    begin
                        dx = longint'(goal_x) - longint'(rob_x);
                        dy = longint'(goal_y) - longint'(rob_y);
                        hd = longint'($signed(rob_head));
                        err = bearing(dy, dx) - hd;
                        if (err > 25736) err -= 51472;
                        else if (err < -25736) err += 51472;
                        r.linear_speed  = 21'((longint'(m_lin) * isqrt(d2)) >> 4);
                        r.angular_speed = 20'(fshift(longint'(m_ang) * err, 4));
                        r.catch_request = 1'b0;
                        r.catch_id      = '0;
                    end
                    else
                    begin
                        r = '0;
                        r.catch_request = 1'b1;
                        r.catch_id      = goal_tag;
                        goal_ok = 1'b0;
                    end
                    cmd_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        ntp_pkg::out_item_t e;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            m_radius <= 16'd2048; m_lin <= 8'd32; m_ang <= 8'd96; m_nearest <= 1'b1;
            rob_x = '0; rob_y = '0; rob_head = '0; pose_ok = 0;
            goal_x = '0; goal_y = '0; goal_tag = '0; goal_ok = 0;
            best_x = '0; best_y = '0; best_tag = '0; best_d2 = '0; list_open = 0;
            fail_count <= 0; n_pursuit <= 0; n_catch <= 0;
            cmd_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr)
                case (cfg_idx)
                    ntp_pkg::REG_RADIUS:  m_radius  <= cfg_data;
                    ntp_pkg::REG_LIN:     m_lin     <= cfg_data[7:0];
                    ntp_pkg::REG_ANG:     m_ang     <= cfg_data[7:0];
                    ntp_pkg::REG_NEAREST: m_nearest <= cfg_data[0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
                steer(in_item);
            if (out_valid && !out_stall)
            begin
                if (cmd_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errs++;
                end
                else
                begin
                    e = cmd_q.pop_front();
                    if (e.catch_request) n_catch <= n_catch + 1;
                    else n_pursuit <= n_pursuit + 1;
                    if (out_item.linear_speed !== e.linear_speed)
                    begin
                        $error("linear_speed expected %0d got %0d",
                               e.linear_speed, out_item.linear_speed);
                        errs++;
                    end
                    if (out_item.angular_speed !== e.angular_speed)
                    begin
                        $error("angular_speed expected %0d got %0d",
                               e.angular_speed, out_item.angular_speed);
                        errs++;
                    end
                    if (out_item.catch_request !== e.catch_request)
                    begin
                        $error("catch_request expected %0d got %0d",
                               e.catch_request, out_item.catch_request);
                        errs++;
                    end
                    if (out_item.catch_id !== e.catch_id)
                    begin
                        $error("catch_id expected %0d got %0d",
                               e.catch_id, out_item.catch_id);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= cmd_q.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// stimulus and verdict for the pursuit controller; checking lives in ntp_checker
module tb_top;

    // opcode with no meaning, must be ignored
    localparam logic [1:0] OP_NONE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ntp_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_stall;
    ntp_pkg::out_item_t out_item;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic [15:0]        cfg_data;
    int                 fail_count, pending, n_pursuit, n_catch;

    // idle percentages for sender and receiver, changed per phase
    int send_idle, recv_idle;
    // long receiver hold-off request, served by its own process
    bit hold_req;
    int n_items;

    nearest_target_pursuit u_dut (.*);

    ntp_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // guard against a hung block
    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold = 0;
                out_stall <= 1'b1;
                while (hold < 400)
                begin
                    @(posedge clk);
                    hold++;
                end
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // one transfer on the input channel, with a random gap first
    // valid stays up after the transfer until the next send or drain
    task automatic send(input ntp_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
    endtask

    function automatic ntp_pkg::in_item_t mk(logic [1:0] op, logic [15:0] x,
                                             logic [15:0] y, logic [15:0] hd,
                                             logic [7:0] tag, logic last);
        ntp_pkg::in_item_t it;
        it.opcode = op; it.pos_x = x; it.pos_y = y; it.heading = hd;
        it.target_id = tag; it.last_in_list = last;
        return it;
    endfunction

    function automatic logic [15:0] rand_head();
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    // random item: mostly well-formed pose / list / tick traffic
    task automatic send_random();
        int sel, len;
        logic [15:0] cx, cy;
        sel = $urandom_range(99);
        cx = 16'($urandom);
        cy = 16'($urandom);
        if (sel < 20)
            send(mk(ntp_pkg::OP_POSE, cx, cy, rand_head(), 8'($urandom), 1'($urandom)));
        else if (sel < 35)
        begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
                send(mk(ntp_pkg::OP_CAND, 16'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom), k == len - 1));
        end
        else if (sel < 42)
            // single-candidate list
            send(mk(ntp_pkg::OP_CAND, 16'($urandom_range(65535)),
                    16'($urandom_range(65535)), 16'($urandom), 8'($urandom), 1'b1));
        else if (sel < 90)
            send(mk(ntp_pkg::OP_TICK, cx, cy, 16'($urandom), 8'($urandom), 1'($urandom)));
        else if (sel < 95)
            send(mk(OP_NONE, cx, cy, 16'($urandom), 8'($urandom), 1'($urandom)));
        else
            send(mk(ntp_pkg::OP_CAND, cx, cy, 16'($urandom), 8'($urandom), 1'b0));
    endtask

    // catch test: pose then one candidate at the same spot then tick
    task automatic send_catch_case(logic [15:0] x, logic [15:0] y, logic [7:0] tag);
        send(mk(ntp_pkg::OP_POSE, x, y, 16'd0, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_CAND, x, y, 16'd0, tag, 1'b1));
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
    endtask

    // registers move only while the block is quiet
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] rad_set[4];
        logic [7:0]  lin_set[4], ang_set[4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_wr   = 1'b0;
        cfg_idx  = ntp_pkg::REG_RADIUS;
        cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b0;
        n_items   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ticks before pose and goal, opcode 3, extremes, catch, ties
        send(mk(ntp_pkg::OP_TICK, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1));
        send(mk(OP_NONE, 16'hffff, 16'hffff, 16'h8000, 8'hff, 1'b1));
        send(mk(ntp_pkg::OP_POSE, 16'd0, 16'd0, 16'sd25736, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_CAND, 16'hffff, 16'hffff, 16'h0, 8'hff, 1'b0));
        send(mk(ntp_pkg::OP_CAND, 16'd100, 16'd100, 16'h0, 8'h01, 1'b0));
        send(mk(ntp_pkg::OP_CAND, 16'd100, 16'd100, 16'h0, 8'h02, 1'b1)); // tie, first wins
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_POSE, 16'hffff, 16'h0, -16'sd25736, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_POSE, 16'hffff, 16'hffff, 16'h0, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_CAND, 16'd0, 16'd0, 16'h0, 8'haa, 1'b1));
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));
        send_catch_case(16'h1234, 16'h4321, 8'h5a);
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));      // goal dropped
        send(mk(ntp_pkg::OP_POSE, 16'h8000, 16'h8000, 16'h0, 8'd0, 1'b0));
        send(mk(ntp_pkg::OP_CAND, 16'h8800, 16'h8000, 16'h0, 8'h11, 1'b1));
        send(mk(ntp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0));      // exactly on radius
        drain();

        // phases across configuration settings and idle patterns
        rad_set = '{16'd0, 16'hffff, 16'd4096, 16'd2048};
        lin_set = '{8'd0, 8'hff, 8'd17, 8'd32};
        ang_set = '{8'hff, 8'd0, 8'd200, 8'd96};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(ntp_pkg::REG_RADIUS, rad_set[ph % 4]);
            write_reg(ntp_pkg::REG_LIN, {8'd0, lin_set[ph % 4]});
            write_reg(ntp_pkg::REG_ANG, {8'd0, ang_set[ph % 4]});
            write_reg(ntp_pkg::REG_NEAREST, 16'(ph % 2));
            cfg_wr <= 1'b0;
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 58; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 58; end
                default: begin send_idle = 35; recv_idle = 35; end
            endcase
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < 145; k++)
            begin
                send_random();
                if (k % 16 == 0)
                    send_catch_case(16'($urandom), 16'($urandom), 8'($urandom));
            end
            drain();
        end

        $display("run covered %0d input transfers, %0d pursuit and %0d catch results",
                 n_items, n_pursuit, n_catch);
        $display("configurations swept over radius, gains, selection mode and idle mixes");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
